// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the frame averager checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define FAA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frame averager assertion failed");

// Check that a sequence never occurs outside reset.
`define FAA_NEVER(label, clk, rst_n, seq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) not (seq)) \
    else $error("frame averager forbidden sequence seen");

`endif

// ===== hw/rtl/faa_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame averager package
// Field widths, register indexes and the control state type.
// ----------------------------------------------------------------------------
package faa_pkg;

  // Pixel and result field widths
  localparam int unsigned ChanWidth       = 8;
  localparam int unsigned NumChan         = 3;
  localparam int unsigned IndexWidth      = 16;
  localparam int unsigned InDataWidth     = NumChan * ChanWidth;
  localparam int unsigned OutDataWidth    = NumChan * ChanWidth + IndexWidth;

  // Configuration registers
  localparam int unsigned FrameCountWidth = 9;
  localparam int unsigned PixelCountWidth = 17;
  localparam int unsigned FrameNumWidth   = 8;
  localparam int unsigned CfgIdxWidth     = 2;
  localparam int unsigned MaxFrames       = 256;

  localparam logic [CfgIdxWidth-1:0] CfgFrameCount = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgPixelCount = 2'd1;

  // Control sequencer states
  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StRead,
    StDiv
  } faa_state_e;

endpackage

// ===== hw/rtl/faa_sum_mem.sv =====
// ----------------------------------------------------------------------------
// Frame averager sum memory
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module faa_sum_mem #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned Width = 48,
  parameter int unsigned AddrW = 16
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/faa_divider.sv =====
// ----------------------------------------------------------------------------
// Frame averager divider
// Three-lane restoring divider, one quotient bit per lane and cycle.
// ----------------------------------------------------------------------------
module faa_divider #(
  parameter int unsigned SumWidth = 16
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 start_i,
  input  logic [faa_pkg::NumChan-1:0][SumWidth-1:0]            dividend_i,
  input  logic [faa_pkg::FrameCountWidth-1:0]                  divisor_i,
  output logic                                                 done_o,
  output logic [faa_pkg::NumChan-1:0][faa_pkg::ChanWidth-1:0]  quotient_o
);

  localparam int unsigned NumChan = faa_pkg::NumChan;
  localparam int unsigned DivW    = faa_pkg::FrameCountWidth;
  localparam int unsigned ChanW   = faa_pkg::ChanWidth;
  localparam int unsigned CntW    = $clog2(SumWidth + 1);

  logic [CntW-1:0]                     cnt_q, cnt_d;
  logic [DivW-1:0]                     div_q;
  logic [NumChan-1:0][DivW-1:0]        rem_q, rem_d;
  logic [NumChan-1:0][SumWidth-1:0]    quo_q, quo_d;
  logic [NumChan-1:0][DivW:0]          trial;
  logic [NumChan-1:0]                  fits;

  // One restoring step per lane: shift in the next dividend bit, try subtract
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      trial[c] = {rem_q[c], quo_q[c][SumWidth-1]};
      fits[c]  = trial[c] >= {1'b0, div_q};
      rem_d[c] = fits[c] ? DivW'(trial[c] - {1'b0, div_q}) : DivW'(trial[c]);
      quo_d[c] = {quo_q[c][SumWidth-2:0], fits[c]};
    end
  end

  // Step counter
  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CntW'(SumWidth);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Load operands on start, advance while steps remain
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = (cnt_q == '0);

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      quotient_o[c] = quo_q[c][ChanW-1:0];
    end
  end

endmodule

// ===== hw/rtl/frame_average_accumulator.sv =====
// ----------------------------------------------------------------------------
// Frame average accumulator
// Averages a burst of frames pixel by pixel with per-pixel sums in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel in raster order, frame after frame;
//   tdata carries red, green and blue. Each pixel's channels are added to the
//   sums stored for its position. On the last frame of a burst the sums are
//   divided by frame_count, sent out on the m_axis channel with the pixel
//   position, and the entry is cleared; tlast marks the last pixel of a frame.
//   Earlier frames give no output. frame_count and pixel_count are written on
//   the cfg channel (index 0 and 1), which is always ready.
// Timing:
//   One pixel is in flight at a time. A pixel of an accumulating frame passes
//   through a RAM read, then an add and write back. A pixel of the final frame
//   also runs through the bit-serial divider, and its result is loaded into
//   the output register once the divider is done and the register is free.
// Reset:
//   After reset a clearing pass zeroes the sum RAM, one entry per cycle, all
//   MAX_PIXELS entries, with s_axis_tready low.
// Stall:
//   A result waits in the output register; the next pixel is accepted, but a
//   finished quotient is held in the divider until the register frees up.
// ----------------------------------------------------------------------------
module frame_average_accumulator #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned SUM_WIDTH  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Pixel input, tdata: red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [faa_pkg::InDataWidth-1:0]      s_axis_tdata,
  // Result output, tdata: red_avg [7:0], green_avg [15:8], blue_avg [23:16],
  // pixel_index [39:24]; tlast: frame_end
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [faa_pkg::OutDataWidth-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast,
  // Configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [faa_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [faa_pkg::PixelCountWidth-1:0]  cfg_data_i
);

  localparam int unsigned NumChan = faa_pkg::NumChan;
  localparam int unsigned ChanW   = faa_pkg::ChanWidth;
  localparam int unsigned FcW     = faa_pkg::FrameCountWidth;
  localparam int unsigned PcW     = faa_pkg::PixelCountWidth;
  localparam int unsigned FnW     = faa_pkg::FrameNumWidth;
  localparam int unsigned IdxW    = faa_pkg::IndexWidth;
  localparam int unsigned AddrW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CmpW    = (AddrW + 1 > PcW) ? AddrW + 1 : PcW;
  localparam int unsigned EntryW  = NumChan * SUM_WIDTH;

  faa_pkg::faa_state_e state_q, state_d;

  logic [FcW-1:0]   frame_count_q;
  logic [PcW-1:0]   pixel_count_q;
  logic [FcW-1:0]   fc_eff;
  logic [CmpW-1:0]  pc_eff;

  logic [AddrW-1:0] pos_q, pos_d;
  logic [FnW-1:0]   frame_q, frame_d;
  logic [AddrW-1:0] clr_q;
  logic             clr_done;

  logic [faa_pkg::InDataWidth-1:0] pix_q;
  logic [IdxW-1:0]  idx_q;
  logic             fend_q;
  logic             last_pix;
  logic             last_frame;

  logic             s_fire;
  logic             m_fire;
  logic             out_free;
  logic             out_load;

  logic             rd_en;
  logic [EntryW-1:0] rd_data;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [EntryW-1:0] wr_data;

  logic [NumChan-1:0][SUM_WIDTH-1:0] sums;
  logic [EntryW-1:0]                 sums_flat;
  logic                              div_start;
  logic                              div_done;
  logic [NumChan-1:0][ChanW-1:0]     quotient;

  logic             out_valid_q;
  logic [faa_pkg::OutDataWidth-1:0] out_data_q;
  logic             out_last_q;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign m_fire   = out_valid_q && m_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FcW'(1);
      pixel_count_q <= PcW'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        faa_pkg::CfgFrameCount: frame_count_q <= cfg_data_i[FcW-1:0];
        faa_pkg::CfgPixelCount: pixel_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp registers into their usable ranges
  always_comb begin
    if (frame_count_q == '0) begin
      fc_eff = FcW'(1);
    end else if (frame_count_q > FcW'(faa_pkg::MaxFrames)) begin
      fc_eff = FcW'(faa_pkg::MaxFrames);
    end else begin
      fc_eff = frame_count_q;
    end

    if (pixel_count_q == '0) begin
      pc_eff = CmpW'(1);
    end else if (CmpW'(pixel_count_q) > CmpW'(MAX_PIXELS)) begin
      pc_eff = CmpW'(MAX_PIXELS);
    end else begin
      pc_eff = CmpW'(pixel_count_q);
    end
  end

  // Position and frame decisions for the pixel being processed
  assign last_pix   = (CmpW'(pos_q) + CmpW'(1)) >= pc_eff;
  assign last_frame = ({1'b0, frame_q} + FcW'(1)) >= fc_eff;
  assign clr_done   = (clr_q == AddrW'(MAX_PIXELS - 1));

  // Add the incoming pixel to the stored sums, wrapping at SUM_WIDTH bits
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      sums[c] = rd_data[c*SUM_WIDTH +: SUM_WIDTH] + SUM_WIDTH'(pix_q[c*ChanW +: ChanW]);
    end
  end

  assign sums_flat = sums;

  // Sequencer: next state, RAM access, divider start and output load
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    frame_d   = frame_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pos_q;
    wr_data   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      faa_pkg::StClear: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        if (clr_done) begin
          state_d = faa_pkg::StIdle;
        end
      end
      faa_pkg::StIdle: begin
        s_axis_tready = 1'b1;
        rd_en         = s_axis_tvalid;
        if (s_axis_tvalid) begin
          state_d = faa_pkg::StRead;
        end
      end
      faa_pkg::StRead: begin
        // Write back the new sum, or zero when this frame closes the burst
        wr_en   = 1'b1;
        wr_data = last_frame ? '0 : sums_flat;
        if (last_pix) begin
          pos_d   = '0;
          frame_d = last_frame ? '0 : frame_q + 1'b1;
        end else begin
          pos_d   = pos_q + 1'b1;
        end
        if (last_frame) begin
          div_start = 1'b1;
          state_d   = faa_pkg::StDiv;
        end else begin
          state_d   = faa_pkg::StIdle;
        end
      end
      faa_pkg::StDiv: begin
        // Hold the quotient until the output register can take it
        if (div_done && out_free) begin
          out_load = 1'b1;
          state_d  = faa_pkg::StIdle;
        end
      end
      default: state_d = faa_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= faa_pkg::StClear;
      pos_q   <= '0;
      frame_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      frame_q <= frame_d;
      if (state_q == faa_pkg::StClear) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Capture the pixel and its position data for the result
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      pix_q <= s_axis_tdata;
    end
    if (state_q == faa_pkg::StRead) begin
      idx_q  <= IdxW'(pos_q);
      fend_q <= last_pix;
    end
  end

  // Sum storage; the sequencer never reads an entry in the cycle it writes it
  faa_sum_mem #(
    .Depth (MAX_PIXELS),
    .Width (EntryW),
    .AddrW (AddrW)
  ) u_sum_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (pos_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  faa_divider #(
    .SumWidth (SUM_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sums),
    .divisor_i  (fc_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {idx_q, quotient[2], quotient[1], quotient[0]};
      out_last_q <= fend_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hw/rtl/faa_checker.sv =====
// ----------------------------------------------------------------------------
// Frame averager checker
// Port-level assertions on the stream channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module faa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [faa_pkg::OutDataWidth-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  // Hold a stalled result and its payload
  `FAA_ASSERT(a_out_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `FAA_ASSERT(a_out_data_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // One pixel in flight: ready drops right after an accepted item
  `FAA_ASSERT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // A result needs at least the RAM read and the divider, so it never rises right after acceptance
  `FAA_NEVER(a_no_early_result, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) ##1 $rose(m_axis_tvalid))

endmodule

bind frame_average_accumulator faa_checker u_faa_checker (.*);
